[sv/tpmmd_pkg.sv]
// ----------------------------------------------------------------------------
// tpmmd_pkg
// Shared types and constants for the three-phase min/max decimator.
// ----------------------------------------------------------------------------
package tpmmd_pkg;

  localparam int NPH       = 3;
  localparam int TW        = 32;
  localparam int VW        = 16;
  localparam int SW        = 32;
  localparam int TOTAL_W   = 16;
  localparam int POINTS_W  = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int SCALE_W   = 17;
  localparam int NSCALE    = 45;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS = 2'd1;

  typedef logic [VW-1:0] volt_t;
  typedef logic [SW-1:0] sum_t;

  typedef struct packed {
    logic [TW-1:0]      start_time;
    volt_t [NPH-1:0]    vmin;
    volt_t [NPH-1:0]    vmax;
    sum_t  [NPH-1:0]    vsum;
    logic [TOTAL_W-1:0] count;
    logic               last;
    volt_t              omax;
  } rec_t;

  typedef enum logic [1:0] {FE_RUN, FE_LOAD, FE_DIV} fe_state_t;
  typedef enum logic [1:0] {BE_IDLE, BE_DIV, BE_OUT} be_state_t;

  // round scale candidates d*10^k in ascending order
  localparam logic [SCALE_W-1:0] SCALE_TBL [NSCALE] = '{
    17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9,
    17'd10, 17'd20, 17'd30, 17'd40, 17'd50, 17'd60, 17'd70, 17'd80, 17'd90,
    17'd100, 17'd200, 17'd300, 17'd400, 17'd500, 17'd600, 17'd700, 17'd800,
    17'd900,
    17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000, 17'd6000, 17'd7000,
    17'd8000, 17'd9000,
    17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000, 17'd60000,
    17'd70000, 17'd80000, 17'd90000
  };

  function automatic logic [SCALE_W-1:0] round_scale(input volt_t m);
    logic [SCALE_W-1:0] res;
    res = SCALE_TBL[NSCALE-1];
    for (int i = NSCALE - 1; i >= 0; i--) begin
      if (SCALE_TBL[i] >= {1'b0, m}) res = SCALE_TBL[i];
    end
    return res;
  endfunction

endpackage

[sv/tpmmd_fifo.sv]
// ----------------------------------------------------------------------------
// tpmmd_fifo
// Two-entry queue of closed bucket records between front and back end.
// ----------------------------------------------------------------------------
module tpmmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tpmmd_pkg::rec_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tpmmd_pkg::rec_t pop_data
);

  tpmmd_pkg::rec_t mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

endmodule

[sv/tpmmd_front.sv]
// ----------------------------------------------------------------------------
// tpmmd_front
// Config registers, bucket boundary tracking and per-bucket accumulation.
// ----------------------------------------------------------------------------
module tpmmd_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tpmmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpmmd_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tpmmd_pkg::TW-1:0]             in_sample_time,
  input  tpmmd_pkg::volt_t [tpmmd_pkg::NPH-1:0] in_volts,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output tpmmd_pkg::rec_t                      push_data
);

  localparam int TOW = tpmmd_pkg::TOTAL_W;
  localparam int PW  = tpmmd_pkg::POINTS_W;
  localparam int NPH = tpmmd_pkg::NPH;

  tpmmd_pkg::fe_state_t state_r, state_nxt;

  logic [TOW-1:0] total_r, total_nxt;
  logic [PW-1:0]  points_r, points_nxt;
  logic [TOW-1:0] quo_r, quo_nxt;
  logic [PW-1:0]  rmd_r, rmd_nxt;
  logic [TOW-1:0] dq_r, dq_nxt;
  logic [PW-1:0]  drem_r, drem_nxt;
  logic [3:0]     dcnt_r, dcnt_nxt;

  logic [TOW-1:0] idx_r, idx_nxt;
  logic [PW-1:0]  bidx_r, bidx_nxt;
  logic [TOW:0]   end_r, end_nxt;
  logic [PW-1:0]  brem_r, brem_nxt;
  logic [TOW-1:0] cnt_r, cnt_nxt;
  logic [tpmmd_pkg::TW-1:0] time_r, time_nxt;
  tpmmd_pkg::volt_t [NPH-1:0] min_r, min_nxt, max_r, max_nxt;
  tpmmd_pkg::sum_t  [NPH-1:0] sum_r, sum_nxt;
  tpmmd_pkg::volt_t omax_r, omax_nxt;

  logic [TOW-1:0] t_eff;
  logic [PW-1:0]  p_eff;
  logic           cfg_hit, acc, first, close, last;
  logic [PW:0]    rs;
  logic           ge;
  logic [PW:0]    bsum;
  logic           bcarry;

  assign cfg_hit = cfg_we && (cfg_index == tpmmd_pkg::REG_TOTAL ||
                              cfg_index == tpmmd_pkg::REG_POINTS);

  always_comb begin
    t_eff = (total_r == '0) ? TOW'(1) : total_r;
    p_eff = (points_r == '0) ? PW'(1) : points_r;
    if ({4'd0, p_eff} > t_eff) p_eff = t_eff[PW-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpmmd_pkg::FE_RUN:  state_nxt = tpmmd_pkg::FE_RUN;
      tpmmd_pkg::FE_LOAD: state_nxt = tpmmd_pkg::FE_DIV;
      tpmmd_pkg::FE_DIV:  if (dcnt_r == 4'd15) state_nxt = tpmmd_pkg::FE_RUN;
      default:            state_nxt = tpmmd_pkg::FE_RUN;
    endcase
    if (cfg_hit) state_nxt = tpmmd_pkg::FE_LOAD;
  end

  // outputs
  always_comb begin
    in_ready   = (state_r == tpmmd_pkg::FE_RUN) && push_ready;
    push_valid = 1'b0;
    if (state_r == tpmmd_pkg::FE_RUN) push_valid = in_valid && close;
  end

  assign acc   = in_valid && in_ready;
  assign first = (cnt_r == '0);
  assign close = ({1'b0, idx_r} + 17'd1) == end_r;
  assign last  = ({1'b0, bidx_r} + 13'd1) >= {1'b0, p_eff};

  // boundary divider step
  always_comb begin
    rs = {drem_r, dq_r[TOW-1]};
    ge = rs >= {1'b0, p_eff};
    bsum   = {1'b0, brem_r} + {1'b0, rmd_r};
    bcarry = bsum >= {1'b0, p_eff};
  end

  always_comb begin
    total_nxt  = total_r;
    points_nxt = points_r;
    quo_nxt    = quo_r;
    rmd_nxt    = rmd_r;
    dq_nxt     = dq_r;
    drem_nxt   = drem_r;
    dcnt_nxt   = dcnt_r;
    idx_nxt    = idx_r;
    bidx_nxt   = bidx_r;
    end_nxt    = end_r;
    brem_nxt   = brem_r;
    cnt_nxt    = cnt_r;
    time_nxt   = time_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    sum_nxt    = sum_r;
    omax_nxt   = omax_r;

    if (state_r == tpmmd_pkg::FE_LOAD) begin
      dq_nxt   = t_eff;
      drem_nxt = '0;
      dcnt_nxt = '0;
    end
    if (state_r == tpmmd_pkg::FE_DIV) begin
      dq_nxt   = {dq_r[TOW-2:0], ge};
      drem_nxt = ge ? PW'(rs - {1'b0, p_eff}) : rs[PW-1:0];
      dcnt_nxt = dcnt_r + 4'd1;
      if (dcnt_r == 4'd15) begin
        quo_nxt  = {dq_r[TOW-2:0], ge};
        rmd_nxt  = ge ? PW'(rs - {1'b0, p_eff}) : rs[PW-1:0];
        end_nxt  = {1'b0, dq_r[TOW-2:0], ge};
        brem_nxt = ge ? PW'(rs - {1'b0, p_eff}) : rs[PW-1:0];
      end
    end

    if (acc) begin
      cnt_nxt = cnt_r + TOW'(1);
      if (first) time_nxt = in_sample_time;
      for (int ph = 0; ph < NPH; ph++) begin
        if (first) begin
          min_nxt[ph] = in_volts[ph];
          max_nxt[ph] = in_volts[ph];
          sum_nxt[ph] = {16'd0, in_volts[ph]};
        end else begin
          if (in_volts[ph] < min_r[ph]) min_nxt[ph] = in_volts[ph];
          if (in_volts[ph] > max_r[ph]) max_nxt[ph] = in_volts[ph];
          sum_nxt[ph] = sum_r[ph] + {16'd0, in_volts[ph]};
        end
      end
      for (int ph = 0; ph < NPH; ph++) begin
        if (in_volts[ph] > omax_nxt) omax_nxt = in_volts[ph];
      end
      if (!close) begin
        idx_nxt = idx_r + TOW'(1);
      end else if (!last) begin
        idx_nxt  = idx_r + TOW'(1);
        bidx_nxt = bidx_r + PW'(1);
        cnt_nxt  = '0;
        end_nxt  = end_r + {1'b0, quo_r} + {16'd0, bcarry};
        brem_nxt = bcarry ? PW'(bsum - {1'b0, p_eff}) : bsum[PW-1:0];
      end else begin
        idx_nxt  = '0;
        bidx_nxt = '0;
        cnt_nxt  = '0;
        end_nxt  = {1'b0, quo_r};
        brem_nxt = rmd_r;
        omax_nxt = '0;
      end
    end

    if (cfg_hit) begin
      if (cfg_index == tpmmd_pkg::REG_TOTAL) total_nxt = cfg_wdata;
      else points_nxt = cfg_wdata[PW-1:0];
      idx_nxt  = '0;
      bidx_nxt = '0;
      cnt_nxt  = '0;
      omax_nxt = '0;
    end
  end

  always_comb begin
    push_data.start_time = first ? in_sample_time : time_r;
    push_data.vmin       = min_nxt;
    push_data.vmax       = max_nxt;
    push_data.vsum       = sum_nxt;
    push_data.count      = cnt_r + TOW'(1);
    push_data.last       = last;
    push_data.omax       = omax_r;
    for (int ph = 0; ph < NPH; ph++) begin
      if (in_volts[ph] > push_data.omax) push_data.omax = in_volts[ph];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tpmmd_pkg::FE_RUN;
      total_r  <= TOW'(1);
      points_r <= PW'(1);
      quo_r    <= TOW'(1);
      rmd_r    <= '0;
      dcnt_r   <= '0;
      idx_r    <= '0;
      bidx_r   <= '0;
      end_r    <= 17'd1;
      brem_r   <= '0;
      cnt_r    <= '0;
      omax_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      points_r <= points_nxt;
      quo_r    <= quo_nxt;
      rmd_r    <= rmd_nxt;
      dcnt_r   <= dcnt_nxt;
      idx_r    <= idx_nxt;
      bidx_r   <= bidx_nxt;
      end_r    <= end_nxt;
      brem_r   <= brem_nxt;
      cnt_r    <= cnt_nxt;
      omax_r   <= omax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    drem_r <= drem_nxt;
    time_r <= time_nxt;
    min_r  <= min_nxt;
    max_r  <= max_nxt;
    sum_r  <= sum_nxt;
  end

endmodule

[sv/tpmmd_back.sv]
// ----------------------------------------------------------------------------
// tpmmd_back
// Mean division per phase, plot scale and the result register.
// ----------------------------------------------------------------------------
module tpmmd_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  tpmmd_pkg::rec_t                       pop_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tpmmd_pkg::rec_t                       res_rec,
  output tpmmd_pkg::volt_t [tpmmd_pkg::NPH-1:0] res_mean,
  output logic [tpmmd_pkg::SCALE_W-1:0]         res_scale
);

  localparam int NPH = tpmmd_pkg::NPH;

  tpmmd_pkg::be_state_t state_r, state_nxt;
  tpmmd_pkg::rec_t rec_r, rec_nxt;
  tpmmd_pkg::volt_t [NPH-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [tpmmd_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [16:0] rs [NPH];
  logic        ge [NPH];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpmmd_pkg::BE_IDLE: if (pop_valid) state_nxt = tpmmd_pkg::BE_DIV;
      tpmmd_pkg::BE_DIV:  if (cnt_r == 4'd15) state_nxt = tpmmd_pkg::BE_OUT;
      tpmmd_pkg::BE_OUT:  if (out_ready) state_nxt = tpmmd_pkg::BE_IDLE;
      default:            state_nxt = tpmmd_pkg::BE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_ready = (state_r == tpmmd_pkg::BE_IDLE);
    out_valid = (state_r == tpmmd_pkg::BE_OUT);
  end

  always_comb begin
    rec_nxt   = rec_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    scale_nxt = scale_r;
    cnt_nxt   = cnt_r;
    for (int ph = 0; ph < NPH; ph++) begin
      rs[ph] = {rem_r[ph], quo_r[ph][15]};
      ge[ph] = rs[ph] >= {1'b0, rec_r.count};
    end
    if (state_r == tpmmd_pkg::BE_IDLE && pop_valid) begin
      rec_nxt   = pop_data;
      cnt_nxt   = '0;
      scale_nxt = pop_data.last ? tpmmd_pkg::round_scale(pop_data.omax) : '0;
      for (int ph = 0; ph < NPH; ph++) begin
        rem_nxt[ph] = pop_data.vsum[ph][31:16];
        quo_nxt[ph] = pop_data.vsum[ph][15:0];
      end
    end
    if (state_r == tpmmd_pkg::BE_DIV) begin
      cnt_nxt = cnt_r + 4'd1;
      for (int ph = 0; ph < NPH; ph++) begin
        rem_nxt[ph] = ge[ph] ? 16'(rs[ph] - {1'b0, rec_r.count}) : rs[ph][15:0];
        quo_nxt[ph] = {quo_r[ph][14:0], ge[ph]};
      end
    end
  end

  assign res_rec   = rec_r;
  assign res_mean  = quo_r;
  assign res_scale = scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpmmd_pkg::BE_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    scale_r <= scale_nxt;
  end

endmodule

[sv/three_phase_minmax_decimator_unit.sv]
// ----------------------------------------------------------------------------
// three_phase_minmax_decimator_unit
// Folds a run of three-phase samples into plot buckets of min, max and mean.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one timestamped sample per item (valid/ready). out_* gives
//   one item per closed bucket with min, max and truncated mean per phase;
//   the final bucket of a run has out_last_point set and the round scale.
//   cfg_we/cfg_index/cfg_wdata write total_samples (0) or output_points (1);
//   each write restarts the run and recomputes the bucket step, holding
//   in_ready low until the bucket step is ready.
// Timing:
//   the front end takes one sample per cycle unless the queue is full or a
//   config write is in progress. A closing bucket goes through a two-entry
//   queue to the back end, whose shared-step mean divider raises out_valid
//   when done; no new bucket is taken until out_ready accepts the result.
// Reset:
//   total_samples and output_points are 1, every sample is one bucket.
// Stalls:
//   a stalled out_ready holds the result; the queue fills and then in_ready
//   drops until the back end drains.
// ----------------------------------------------------------------------------
module three_phase_minmax_decimator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tpmmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpmmd_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [31:0]                         in_sample_time,
  input  logic [15:0]                         in_phase1_volts,
  input  logic [15:0]                         in_phase2_volts,
  input  logic [15:0]                         in_phase3_volts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [31:0]                         out_bucket_time,
  output logic [15:0]                         out_min_phase1,
  output logic [15:0]                         out_max_phase1,
  output logic [15:0]                         out_mean_phase1,
  output logic [15:0]                         out_min_phase2,
  output logic [15:0]                         out_max_phase2,
  output logic [15:0]                         out_mean_phase2,
  output logic [15:0]                         out_min_phase3,
  output logic [15:0]                         out_max_phase3,
  output logic [15:0]                         out_mean_phase3,
  output logic                                out_last_point,
  output logic [16:0]                         out_scale_max
);

  tpmmd_pkg::volt_t [tpmmd_pkg::NPH-1:0] volts;
  tpmmd_pkg::volt_t [tpmmd_pkg::NPH-1:0] mean;
  tpmmd_pkg::rec_t push_data, pop_data, res_rec;
  logic push_valid, push_ready, pop_valid, pop_ready;

  assign volts[0] = in_phase1_volts;
  assign volts[1] = in_phase2_volts;
  assign volts[2] = in_phase3_volts;

  tpmmd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_time (in_sample_time),
    .in_volts       (volts),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  tpmmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tpmmd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_rec   (res_rec),
    .res_mean  (mean),
    .res_scale (out_scale_max)
  );

  assign out_bucket_time = res_rec.start_time;
  assign out_min_phase1  = res_rec.vmin[0];
  assign out_max_phase1  = res_rec.vmax[0];
  assign out_mean_phase1 = mean[0];
  assign out_min_phase2  = res_rec.vmin[1];
  assign out_max_phase2  = res_rec.vmax[1];
  assign out_mean_phase2 = mean[1];
  assign out_min_phase3  = res_rec.vmin[2];
  assign out_max_phase3  = res_rec.vmax[2];
  assign out_mean_phase3 = mean[2];
  assign out_last_point  = res_rec.last;

endmodule
